FILE: rtl/lfc_pkg.sv
// Shared types, constants and the power-table generator for the lux block.
// No dependencies; every other file in rtl/ refers to this package by scope.
`timescale 1ns / 1ps

package lfc_pkg;

   // Defaults for the top-level parameters
   localparam int RATIO_FRAC_BITS_DEF = 12;
   localparam int LUX_FRAC_BITS_DEF   = 8;
   localparam int POW_TABLE_DEPTH_DEF = 512;

   // Fixed field widths
   localparam int COUNT_W = 16;
   localparam int LUX_W   = 19;
   localparam int SEG_W   = 3;
   localparam int POW_W   = 16;   // table entry is a fraction of 2^16

   // Lux coefficients: scaled by 10^4 for the lower three segments, 10^5 for the top one
   localparam int C_LOW_B  = 304;
   localparam int C_LOW_P  = 620;
   localparam int C_MID_B  = 224;
   localparam int C_MID_I  = 310;
   localparam int C_HIGH_B = 128;
   localparam int C_HIGH_I = 153;
   localparam int C_TOP_B  = 146;
   localparam int C_TOP_I  = 112;
   localparam int DEC_STEP = 10;  // brings the 10^4 segments onto the 10^5 scale

   // Common divisor 100000 = 2^5 * 3125
   localparam int DIV_POW2 = 5;
   localparam int DIV_ODD  = 3125;

   // Reciprocal of DIV_ODD, exact to within one for numerators below 2^RECIP_SHIFT
   localparam int     RECIP_SHIFT = 31;
   localparam int     RECIP_W     = 20;
   localparam longint RECIP_MUL   = (longint'(1) << RECIP_SHIFT) / DIV_ODD;
   localparam int     NQ_W        = RECIP_SHIFT;
   localparam longint SAT_LIM     = (longint'(1) << LUX_W) * DIV_ODD;

   // Width of the bignum used when building the power table
   localparam int BIGNUM_W = 192;

   typedef enum logic [SEG_W-1:0] {
      SEG_LOW  = 3'd0,
      SEG_MID  = 3'd1,
      SEG_HIGH = 3'd2,
      SEG_TOP  = 3'd3,
      SEG_ZERO = 3'd4
   } seg_type;

   // Largest y with y^5 * (2*depth)^7 <= k^7 * (2^16)^5, i.e. floor(2^16 * (k/(2*depth))^1.4)
   function automatic logic [POW_W-1:0] pow_entry(input int k, input int depth);
      logic [BIGNUM_W-1:0] den7;
      logic [BIGNUM_W-1:0] rhs;
      logic [BIGNUM_W-1:0] lhs;
      logic [POW_W-1:0]    y;
      logic [POW_W-1:0]    trial;
      den7 = BIGNUM_W'(1);
      rhs  = BIGNUM_W'(1);
      for (int n = 0; n < 7; n++) begin
         den7 = den7 * BIGNUM_W'(2 * depth);
         rhs  = rhs * BIGNUM_W'(k);
      end
      rhs = rhs << (5 * POW_W);
      y   = '0;
      for (int bit_n = POW_W - 1; bit_n >= 0; bit_n--) begin
         trial = y | (POW_W'(1) << bit_n);
         lhs   = den7;
         for (int n = 0; n < 5; n++) begin
            lhs = lhs * BIGNUM_W'(trial);
         end
         if (lhs <= rhs) begin
            y = trial;
         end
      end
      return y;
   endfunction

endpackage

FILE: rtl/lfc_ratio_div.sv
// Pipelined restoring divider: infrared * 2^RATIO_FRAC_BITS / broadband, one quotient bit a stage.
// Depends on lfc_pkg.
`timescale 1ns / 1ps

module lfc_ratio_div #(
   parameter int RATIO_FRAC_BITS = lfc_pkg::RATIO_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [lfc_pkg::COUNT_W-1:0]       in_b,
   input  logic [lfc_pkg::COUNT_W-1:0]       in_i,
   input  lfc_pkg::seg_type                  in_seg,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [lfc_pkg::COUNT_W-1:0]       out_b,
   output logic [lfc_pkg::COUNT_W-1:0]       out_i,
   output lfc_pkg::seg_type                  out_seg,
   output logic [RATIO_FRAC_BITS-1:0]        out_q
);

   localparam int QW = RATIO_FRAC_BITS;
   localparam int CW = lfc_pkg::COUNT_W;

   logic                v_ff   [QW];
   logic [QW:0]         rdy;
   logic [CW-1:0]       b_ff   [QW];
   logic [CW-1:0]       i_ff   [QW];
   logic [CW-1:0]       rem_ff [QW];
   lfc_pkg::seg_type    seg_ff [QW];
   logic [QW-1:0]       q_ff   [QW];

   assign rdy[QW]  = out_ready;
   assign in_ready = rdy[0];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic             src_v;
      logic [CW-1:0]    src_b;
      logic [CW-1:0]    src_i;
      logic [CW-1:0]    src_rem;
      lfc_pkg::seg_type src_seg;
      logic [QW-1:0]    src_q;
      logic [CW:0]      rem_x2;
      logic             take;
      logic [CW-1:0]    rem_in;
      logic [QW-1:0]    q_in;

      if (k == 0) begin : g_head
         // Only the low segment needs the ratio; other items divide zero
         assign src_v   = in_valid;
         assign src_b   = in_b;
         assign src_i   = in_i;
         assign src_seg = in_seg;
         assign src_rem = (in_seg == lfc_pkg::SEG_LOW) ? in_i : '0;
         assign src_q   = '0;
      end else begin : g_body
         assign src_v   = v_ff[k-1];
         assign src_b   = b_ff[k-1];
         assign src_i   = i_ff[k-1];
         assign src_seg = seg_ff[k-1];
         assign src_rem = rem_ff[k-1];
         assign src_q   = q_ff[k-1];
      end

      assign rem_x2 = {src_rem, 1'b0};
      assign take   = (rem_x2 >= {1'b0, src_b});
      assign rem_in = take ? CW'(rem_x2 - {1'b0, src_b}) : rem_x2[CW-1:0];
      assign q_in   = src_q | (QW'(take) << (QW - 1 - k));
      assign rdy[k] = ~v_ff[k] | rdy[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && src_v) begin
            b_ff[k]   <= src_b;
            i_ff[k]   <= src_i;
            seg_ff[k] <= src_seg;
            rem_ff[k] <= rem_in;
            q_ff[k]   <= q_in;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_b     = b_ff[QW-1];
   assign out_i     = i_ff[QW-1];
   assign out_seg   = seg_ff[QW-1];
   assign out_q     = q_ff[QW-1];

endmodule

FILE: rtl/lfc_pow_rom.sv
// Ratio-to-index scaling and the ratio^1.4 lookup table, two register stages.
// Depends on lfc_pkg (pow_entry builds the table at elaboration).
`timescale 1ns / 1ps

module lfc_pow_rom #(
   parameter int RATIO_FRAC_BITS = lfc_pkg::RATIO_FRAC_BITS_DEF,
   parameter int POW_TABLE_DEPTH = lfc_pkg::POW_TABLE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [lfc_pkg::COUNT_W-1:0]   in_b,
   input  logic [lfc_pkg::COUNT_W-1:0]   in_i,
   input  lfc_pkg::seg_type              in_seg,
   input  logic [RATIO_FRAC_BITS-1:0]    in_q,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [lfc_pkg::COUNT_W-1:0]   out_b,
   output logic [lfc_pkg::COUNT_W-1:0]   out_i,
   output lfc_pkg::seg_type              out_seg,
   output logic [lfc_pkg::POW_W-1:0]     out_p
);

   localparam int QW     = RATIO_FRAC_BITS;
   localparam int CW     = lfc_pkg::COUNT_W;
   localparam int PW     = lfc_pkg::POW_W;
   localparam int IDX_W  = $clog2(POW_TABLE_DEPTH);
   localparam int IDXF_W = IDX_W + 1;
   localparam int PROD_W = QW + IDXF_W;

   logic [PW-1:0] rom [POW_TABLE_DEPTH];

   for (genvar k = 0; k < POW_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [PW-1:0] ENTRY = lfc_pkg::pow_entry(k, POW_TABLE_DEPTH);
      assign rom[k] = ENTRY;
   end

   logic [PROD_W-1:0] prod;
   logic [IDXF_W-1:0] idx_full;
   logic [IDX_W-1:0]  idx_in;

   logic              a_valid_ff;
   logic              a_ready;
   logic [CW-1:0]     a_b_ff;
   logic [CW-1:0]     a_i_ff;
   lfc_pkg::seg_type  a_seg_ff;
   logic [IDX_W-1:0]  a_idx_ff;

   logic              r_valid_ff;
   logic              r_ready;
   logic [CW-1:0]     r_b_ff;
   logic [CW-1:0]     r_i_ff;
   lfc_pkg::seg_type  r_seg_ff;
   logic [PW-1:0]     r_p_ff;

   // index = q * 2*depth / 2^QW, clamped to the last entry
   assign prod     = PROD_W'(in_q) * PROD_W'(2 * POW_TABLE_DEPTH);
   assign idx_full = prod[PROD_W-1:QW];
   assign idx_in   = (idx_full > IDXF_W'(POW_TABLE_DEPTH - 1)) ?
                     IDX_W'(POW_TABLE_DEPTH - 1) : idx_full[IDX_W-1:0];

   assign r_ready  = ~r_valid_ff | out_ready;
   assign a_ready  = ~a_valid_ff | r_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (r_ready) begin
            r_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_b_ff   <= in_b;
         a_i_ff   <= in_i;
         a_seg_ff <= in_seg;
         a_idx_ff <= idx_in;
      end
      if (r_ready && a_valid_ff) begin
         r_b_ff   <= a_b_ff;
         r_i_ff   <= a_i_ff;
         r_seg_ff <= a_seg_ff;
         r_p_ff   <= rom[a_idx_ff];
      end
   end

   assign out_valid = r_valid_ff;
   assign out_b     = r_b_ff;
   assign out_i     = r_i_ff;
   assign out_seg   = r_seg_ff;
   assign out_p     = r_p_ff;

endmodule

FILE: rtl/lfc_lux_scale.sv
// Segment numerator, fixed-point scaling, saturation and constant division by 10^5.
// Depends on lfc_pkg; six register stages with the output register last.
`timescale 1ns / 1ps

module lfc_lux_scale #(
   parameter int LUX_FRAC_BITS = lfc_pkg::LUX_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [lfc_pkg::COUNT_W-1:0]   in_b,
   input  logic [lfc_pkg::COUNT_W-1:0]   in_i,
   input  lfc_pkg::seg_type              in_seg,
   input  logic [lfc_pkg::POW_W-1:0]     in_p,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [lfc_pkg::LUX_W-1:0]     out_lux,
   output lfc_pkg::seg_type              out_seg
);

   localparam int CW        = lfc_pkg::COUNT_W;
   localparam int PW        = lfc_pkg::POW_W;
   localparam int LW        = lfc_pkg::LUX_W;
   localparam int BP_W      = CW + PW;
   localparam int LIN_W     = CW + 10;
   localparam int NUM_W     = CW + PW + 12;
   localparam int TW        = NUM_W + 4;
   localparam int SC_W      = TW + LUX_FRAC_BITS;
   localparam int NQ_W      = lfc_pkg::NQ_W;
   localparam int EST_W     = NQ_W + lfc_pkg::RECIP_W;
   localparam int LOW_SHIFT = PW + lfc_pkg::DIV_POW2 - LUX_FRAC_BITS;

   // ---- stage 1: B*p product and linear numerator ----
   logic                     s1_valid_ff;
   logic                     s1_ready;
   logic [CW-1:0]            s1_b_ff;
   lfc_pkg::seg_type         s1_seg_ff;
   logic [BP_W-1:0]          s1_bp_ff;
   logic signed [LIN_W-1:0]  s1_lin_ff;
   logic [BP_W-1:0]          s1_bp_in;
   logic signed [LIN_W-1:0]  s1_lin_in;

   assign s1_bp_in = BP_W'(in_b) * BP_W'(in_p);

   always_comb begin
      case (in_seg)
         lfc_pkg::SEG_MID: begin
            s1_lin_in = $signed(LIN_W'(in_b) * LIN_W'(lfc_pkg::C_MID_B))
                      - $signed(LIN_W'(in_i) * LIN_W'(lfc_pkg::C_MID_I));
         end
         lfc_pkg::SEG_HIGH: begin
            s1_lin_in = $signed(LIN_W'(in_b) * LIN_W'(lfc_pkg::C_HIGH_B))
                      - $signed(LIN_W'(in_i) * LIN_W'(lfc_pkg::C_HIGH_I));
         end
         lfc_pkg::SEG_TOP: begin
            s1_lin_in = $signed(LIN_W'(in_b) * LIN_W'(lfc_pkg::C_TOP_B))
                      - $signed(LIN_W'(in_i) * LIN_W'(lfc_pkg::C_TOP_I));
         end
         default: begin
            s1_lin_in = '0;
         end
      endcase
   end

   // ---- stage 2: full numerator ----
   logic                     s2_valid_ff;
   logic                     s2_ready;
   lfc_pkg::seg_type         s2_seg_ff;
   logic signed [NUM_W-1:0]  s2_num_ff;
   logic [NUM_W-1:0]         low_pos;
   logic [NUM_W-1:0]         low_neg;
   logic signed [NUM_W-1:0]  s2_num_in;

   assign low_pos = (NUM_W'(s1_b_ff) * NUM_W'(lfc_pkg::C_LOW_B)) << PW;
   assign low_neg = NUM_W'(s1_bp_ff) * NUM_W'(lfc_pkg::C_LOW_P);

   always_comb begin
      if (s1_seg_ff == lfc_pkg::SEG_LOW) begin
         s2_num_in = $signed(low_pos - low_neg);
      end else begin
         s2_num_in = NUM_W'(s1_lin_ff);
      end
   end

   // ---- stage 3: scale by 2^LUX_FRAC_BITS, strip 2^5 of the divisor, saturate ----
   logic                     s3_valid_ff;
   logic                     s3_ready;
   lfc_pkg::seg_type         s3_seg_ff;
   logic [NQ_W-1:0]          s3_nq_ff;
   logic                     s3_sat_ff;
   logic                     s3_zero_ff;
   logic                     pos;
   logic [TW-1:0]            mag;
   logic [TW-1:0]            t;
   logic [SC_W-1:0]          scaled;

   assign pos = ~s2_num_ff[NUM_W-1] && (s2_num_ff != '0);
   assign mag = TW'(s2_num_ff[NUM_W-2:0]);
   assign t   = (s2_seg_ff == lfc_pkg::SEG_TOP) ? mag : mag * TW'(lfc_pkg::DEC_STEP);

   always_comb begin
      if (s2_seg_ff == lfc_pkg::SEG_LOW) begin
         scaled = SC_W'(t) >> LOW_SHIFT;
      end else begin
         scaled = (SC_W'(t) << LUX_FRAC_BITS) >> lfc_pkg::DIV_POW2;
      end
   end

   // ---- stage 4: quotient estimate from the reciprocal ----
   logic                     s4_valid_ff;
   logic                     s4_ready;
   lfc_pkg::seg_type         s4_seg_ff;
   logic [NQ_W-1:0]          s4_nq_ff;
   logic                     s4_sat_ff;
   logic                     s4_zero_ff;
   logic [LW-1:0]            s4_qe_ff;
   logic [EST_W-1:0]         est;

   assign est = EST_W'(s3_nq_ff) * EST_W'(lfc_pkg::RECIP_MUL);

   // ---- stage 5: back-multiply the estimate ----
   logic                     s5_valid_ff;
   logic                     s5_ready;
   lfc_pkg::seg_type         s5_seg_ff;
   logic [NQ_W-1:0]          s5_nq_ff;
   logic                     s5_sat_ff;
   logic                     s5_zero_ff;
   logic [LW-1:0]            s5_qe_ff;
   logic [NQ_W-1:0]          s5_pr_ff;

   // ---- stage 6: correct by one, apply saturation and zero ----
   logic                     s6_valid_ff;
   logic                     s6_ready;
   lfc_pkg::seg_type         s6_seg_ff;
   logic [LW-1:0]            s6_lux_ff;
   logic [NQ_W-1:0]          rem;
   logic [LW-1:0]            s6_lux_in;

   assign rem = s5_nq_ff - s5_pr_ff;

   always_comb begin
      if (s5_zero_ff) begin
         s6_lux_in = '0;
      end else if (s5_sat_ff) begin
         s6_lux_in = '1;
      end else if (rem >= NQ_W'(lfc_pkg::DIV_ODD)) begin
         s6_lux_in = s5_qe_ff + LW'(1);
      end else begin
         s6_lux_in = s5_qe_ff;
      end
   end

   // ---- flow control ----
   assign s6_ready = ~s6_valid_ff | out_ready;
   assign s5_ready = ~s5_valid_ff | s6_ready;
   assign s4_ready = ~s4_valid_ff | s5_ready;
   assign s3_ready = ~s3_valid_ff | s4_ready;
   assign s2_ready = ~s2_valid_ff | s3_ready;
   assign s1_ready = ~s1_valid_ff | s2_ready;
   assign in_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (s5_ready) begin
            s5_valid_ff <= s4_valid_ff;
         end
         if (s6_ready) begin
            s6_valid_ff <= s5_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_b_ff   <= in_b;
         s1_seg_ff <= in_seg;
         s1_bp_ff  <= s1_bp_in;
         s1_lin_ff <= s1_lin_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_seg_ff <= s1_seg_ff;
         s2_num_ff <= s2_num_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_seg_ff  <= s2_seg_ff;
         s3_nq_ff   <= scaled[NQ_W-1:0];
         s3_sat_ff  <= pos && (scaled >= SC_W'(lfc_pkg::SAT_LIM));
         s3_zero_ff <= ~pos;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_seg_ff  <= s3_seg_ff;
         s4_nq_ff   <= s3_nq_ff;
         s4_sat_ff  <= s3_sat_ff;
         s4_zero_ff <= s3_zero_ff;
         s4_qe_ff   <= est[lfc_pkg::RECIP_SHIFT+LW-1:lfc_pkg::RECIP_SHIFT];
      end
      if (s5_ready && s4_valid_ff) begin
         s5_seg_ff  <= s4_seg_ff;
         s5_nq_ff   <= s4_nq_ff;
         s5_sat_ff  <= s4_sat_ff;
         s5_zero_ff <= s4_zero_ff;
         s5_qe_ff   <= s4_qe_ff;
         s5_pr_ff   <= NQ_W'(s4_qe_ff) * NQ_W'(lfc_pkg::DIV_ODD);
      end
      if (s6_ready && s5_valid_ff) begin
         s6_seg_ff <= s5_seg_ff;
         s6_lux_ff <= s6_lux_in;
      end
   end

   assign out_valid = s6_valid_ff;
   assign out_lux   = s6_lux_ff;
   assign out_seg   = s6_seg_ff;

endmodule

FILE: rtl/lux_from_two_channel_counts_top.sv
// Lux from two photodiode counts. Each req_ transaction carries a broadband (visible plus
// infrared) and an infrared-only 16-bit count; each rsp_ transaction returns illuminance in
// units of 2^-LUX_FRAC_BITS lux (saturated at 2^19-1) and a segment code: 0..3 for an
// infrared/broadband ratio up to 0.5, 0.61, 0.80 and 1.30, and 4 for a zero result (zero
// broadband, zero infrared, or ratio above 1.30). Segments are picked by exact integer
// compares; the lowest segment also uses ratio^1.4 from a constant table indexed by the
// fixed-point ratio. One transaction is accepted every clock unless rsp_ready stalls the
// pipeline. Stages: one classify stage, one long-division stage per ratio bit, an index
// stage and a table read, then six stages of numerator, scaling and division by 10^5.
// The divider chain sets the depth. Every stage carries its own valid bit and loads whenever
// it is empty or its successor moves, so bubbles close up under back-pressure. The block
// holds no state between transactions and needs no initialization after reset.
// Depends on lfc_pkg, lfc_ratio_div, lfc_pow_rom, lfc_lux_scale.
`timescale 1ns / 1ps

module lux_from_two_channel_counts_top #(
   parameter int RATIO_FRAC_BITS = lfc_pkg::RATIO_FRAC_BITS_DEF,
   parameter int LUX_FRAC_BITS   = lfc_pkg::LUX_FRAC_BITS_DEF,
   parameter int POW_TABLE_DEPTH = lfc_pkg::POW_TABLE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lfc_pkg::COUNT_W-1:0]   req_broadband_count,
   input  logic [lfc_pkg::COUNT_W-1:0]   req_infrared_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lfc_pkg::LUX_W-1:0]     rsp_lux_value,
   output logic [lfc_pkg::SEG_W-1:0]     rsp_segment
);

   localparam int CW    = lfc_pkg::COUNT_W;
   localparam int CMP_W = CW + 7;   // wide enough for 100 * count

   // ---- classify: exact compares of scaled counts ----
   logic [CMP_W-1:0]  b_w;
   logic [CMP_W-1:0]  i_w;
   lfc_pkg::seg_type  cls_seg_in;

   logic              cls_valid_ff;
   logic              cls_ready;
   logic [CW-1:0]     cls_b_ff;
   logic [CW-1:0]     cls_i_ff;
   lfc_pkg::seg_type  cls_seg_ff;

   assign b_w = CMP_W'(req_broadband_count);
   assign i_w = CMP_W'(req_infrared_count);

   always_comb begin
      if (b_w == '0 || i_w == '0 || i_w * CMP_W'(10) > b_w * CMP_W'(13)) begin
         cls_seg_in = lfc_pkg::SEG_ZERO;
      end else if (i_w * CMP_W'(2) <= b_w) begin
         cls_seg_in = lfc_pkg::SEG_LOW;
      end else if (i_w * CMP_W'(100) <= b_w * CMP_W'(61)) begin
         cls_seg_in = lfc_pkg::SEG_MID;
      end else if (i_w * CMP_W'(5) <= b_w * CMP_W'(4)) begin
         cls_seg_in = lfc_pkg::SEG_HIGH;
      end else begin
         cls_seg_in = lfc_pkg::SEG_TOP;
      end
   end

   // ---- downstream handshakes ----
   logic                          div_in_ready;
   logic                          div_valid;
   logic                          div_ready;
   logic [CW-1:0]                 div_b;
   logic [CW-1:0]                 div_i;
   lfc_pkg::seg_type              div_seg;
   logic [RATIO_FRAC_BITS-1:0]    div_q;

   logic                          pow_valid;
   logic                          pow_ready;
   logic [CW-1:0]                 pow_b;
   logic [CW-1:0]                 pow_i;
   lfc_pkg::seg_type              pow_seg;
   logic [lfc_pkg::POW_W-1:0]     pow_p;

   lfc_pkg::seg_type              lux_seg;

   // Hold the classify register until the divider head can take it
   assign cls_ready = ~cls_valid_ff | div_in_ready;
   assign req_ready = cls_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_valid_ff <= 1'b0;
      end else if (cls_ready) begin
         cls_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cls_ready && req_valid) begin
         cls_b_ff   <= req_broadband_count;
         cls_i_ff   <= req_infrared_count;
         cls_seg_ff <= cls_seg_in;
      end
   end

   // ---- ratio: one quotient bit per stage ----
   lfc_ratio_div #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cls_valid_ff),
      .in_ready  (div_in_ready),
      .in_b      (cls_b_ff),
      .in_i      (cls_i_ff),
      .in_seg    (cls_seg_ff),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_b     (div_b),
      .out_i     (div_i),
      .out_seg   (div_seg),
      .out_q     (div_q)
   );

   // ---- ratio^1.4 lookup ----
   lfc_pow_rom #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS),
      .POW_TABLE_DEPTH (POW_TABLE_DEPTH)
   ) u_pow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_b      (div_b),
      .in_i      (div_i),
      .in_seg    (div_seg),
      .in_q      (div_q),
      .out_valid (pow_valid),
      .out_ready (pow_ready),
      .out_b     (pow_b),
      .out_i     (pow_i),
      .out_seg   (pow_seg),
      .out_p     (pow_p)
   );

   // ---- numerator, scaling, divide by 10^5; last stage is the output register ----
   lfc_lux_scale #(
      .LUX_FRAC_BITS (LUX_FRAC_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pow_valid),
      .in_ready  (pow_ready),
      .in_b      (pow_b),
      .in_i      (pow_i),
      .in_seg    (pow_seg),
      .in_p      (pow_p),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_lux   (rsp_lux_value),
      .out_seg   (lux_seg)
   );

   assign rsp_segment = lux_seg;

endmodule
